// File: sv/ahg_pkg.sv
// ----------------------------------------------------------------------------
// ahg_pkg
// Shared widths, register indexes and types of the auto-scaling history graph.
// ----------------------------------------------------------------------------
`default_nettype none

package ahg_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BH_W     = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned PROD_W   = SAMPLE_W + BH_W;   // value * full height
  localparam int unsigned NUM_W    = PROD_W + 1;        // 2*v*bh + max
  localparam int unsigned DIV_W    = SAMPLE_W + 1;      // 2*max

  // Configuration register indexes (word address)
  localparam int unsigned       REG_IDX_W      = 2;
  localparam logic [REG_IDX_W-1:0] REG_FULL_HEIGHT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR_MAX   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_EN    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [BH_W-1:0]     FULL_HEIGHT_RST = 8'd14;
  localparam logic [SAMPLE_W-1:0] FLOOR_MAX_RST   = 16'd100;

  // Request into the height scaler
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [BH_W-1:0]     full_height;
    logic [SAMPLE_W-1:0] divisor;     // never zero
  } scale_req_t;

endpackage : ahg_pkg

`default_nettype wire

// File: sv/autoscale_history_graph.sv
// ----------------------------------------------------------------------------
// autoscale_history_graph
// One graph series: circular sample history with running-maximum scaling.
// ----------------------------------------------------------------------------
// A single-height transaction goes from accept through S_GO, S_SCL and S_OUT
// into the output register. Rescale: each slot in turn passes RAM read, load,
// scaler start, scaler wait and output; a rescan on peak loss first reads every
// slot (S_SCAN_RD, S_SCAN_CMP). One transaction at a time; the next is taken
// once the last result enters the output register; result stalls hold S_OUT.
// Reset clears history valid bits, pointers, control and config regs at once.
// ----------------------------------------------------------------------------
`default_nettype none

module autoscale_history_graph
  import ahg_pkg::*;
#(
  parameter int unsigned SIZE = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Sample channel
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  // Result channel
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [POS_W-1:0]           position_o,
  output      logic [BH_W-1:0]            bar_height_o,
  output      logic [SAMPLE_W-1:0]        full_scale_o,
  output      logic                       last_o,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);

  localparam int unsigned AW = $clog2(SIZE);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SIZE - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_RD       = 3'd3;
  localparam logic [2:0] S_LD       = 3'd4;
  localparam logic [2:0] S_GO       = 3'd5;
  localparam logic [2:0] S_SCL      = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  // Configuration registers
  logic [BH_W-1:0]     full_height_q;
  logic [SAMPLE_W-1:0] floor_max_q;
  logic                scale_en_q;

  // Control state
  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       wr_pos_q, wr_pos_d;
  logic [AW-1:0]       peak_pos_q, peak_pos_d;
  logic [SAMPLE_W-1:0] run_max_q, run_max_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic                all_q, all_d;
  logic [AW-1:0]       cand_pos_q, cand_pos_d;
  logic [SAMPLE_W-1:0] cand_val_q, cand_val_d;
  logic [SAMPLE_W-1:0] val_q, val_d;

  // Output register
  logic                out_valid_q;
  logic [AW-1:0]       out_pos_q;
  logic [BH_W-1:0]     out_bar_q;
  logic [SAMPLE_W-1:0] out_fs_q;
  logic                out_last_q;

  logic                in_acc;
  logic                cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [SAMPLE_W-1:0] smp;
  logic [AW-1:0]       pos_nxt;
  logic [SAMPLE_W-1:0] rd_data;
  logic                out_load;
  logic                slot_last;
  logic                scl_start;
  logic                scl_done;
  logic [BH_W-1:0]     scl_height;
  scale_req_t          scl_req;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign smp        = sample_i[SAMPLE_W-1] ? '0 : sample_i;
  assign pos_nxt    = (wr_pos_q == LAST_SLOT) ? '0 : (wr_pos_q + 1'b1);
  assign slot_last  = (slot_q == LAST_SLOT);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign scl_start  = (state_q == S_GO);

  // APB access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_FULL_HEIGHT: prdata = 32'(full_height_q);
      REG_FLOOR_MAX:   prdata = 32'(floor_max_q);
      REG_SCALE_EN:    prdata = 32'(scale_en_q);
      default:         prdata = '0;
    endcase
  end

  // History RAM
  ahg_hist_mem #(
    .DEPTH (SIZE),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_acc),
    .waddr_i (pos_nxt),
    .wdata_i (smp),
    .raddr_i (slot_q),
    .rdata_o (rd_data)
  );

  // Height scaler
  assign scl_req.value       = val_q;
  assign scl_req.full_height = full_height_q;
  assign scl_req.divisor     = (run_max_q == '0) ? SAMPLE_W'(1) : run_max_q;

  ahg_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .req_i    (scl_req),
    .done_o   (scl_done),
    .height_o (scl_height)
  );

  // Sequencer: update, optional rescan, then one or SIZE heights
  always_comb begin
    state_d    = state_q;
    wr_pos_d   = wr_pos_q;
    peak_pos_d = peak_pos_q;
    run_max_d  = run_max_q;
    slot_d     = slot_q;
    all_d      = all_q;
    cand_pos_d = cand_pos_q;
    cand_val_d = cand_val_q;
    val_d      = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wr_pos_d = pos_nxt;
          val_d    = smp;
          slot_d   = pos_nxt;
          all_d    = 1'b0;
          priority if (!scale_en_q) begin
            state_d = S_GO;
          end else if (smp > run_max_q) begin
            peak_pos_d = pos_nxt;
            run_max_d  = smp;
            all_d      = 1'b1;
            slot_d     = '0;
            state_d    = S_RD;
          end else if ((peak_pos_q == pos_nxt) && (run_max_q > floor_max_q)) begin
            cand_pos_d = pos_nxt;
            cand_val_d = smp;
            all_d      = 1'b1;
            slot_d     = '0;
            state_d    = S_SCAN_RD;
          end else begin
            state_d = S_GO;
          end
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rd_data > cand_val_q) begin
          cand_pos_d = slot_q;
          cand_val_d = rd_data;
        end
        if (slot_last) begin
          peak_pos_d = (rd_data > cand_val_q) ? slot_q : cand_pos_q;
          run_max_d  = (cand_val_d > floor_max_q) ? cand_val_d : floor_max_q;
          slot_d     = '0;
          state_d    = S_RD;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        val_d   = rd_data;
        state_d = S_GO;
      end
      S_GO: begin
        state_d = S_SCL;
      end
      S_SCL: begin
        if (scl_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (!all_q || slot_last) begin
            state_d = S_IDLE;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Writing floor_max reloads the tracked maximum
    if (cfg_wr && (cfg_idx == REG_FLOOR_MAX)) begin
      run_max_d = pwdata[SAMPLE_W-1:0];
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wr_pos_q      <= '0;
      peak_pos_q    <= '0;
      run_max_q     <= FLOOR_MAX_RST;
      slot_q        <= '0;
      all_q         <= 1'b0;
      full_height_q <= FULL_HEIGHT_RST;
      floor_max_q   <= FLOOR_MAX_RST;
      scale_en_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_pos_q   <= wr_pos_d;
      peak_pos_q <= peak_pos_d;
      run_max_q  <= run_max_d;
      slot_q     <= slot_d;
      all_q      <= all_d;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FULL_HEIGHT: full_height_q <= pwdata[BH_W-1:0];
          REG_FLOOR_MAX:   floor_max_q   <= pwdata[SAMPLE_W-1:0];
          REG_SCALE_EN:    scale_en_q    <= pwdata[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cand_pos_q <= cand_pos_d;
    cand_val_q <= cand_val_d;
    val_q      <= val_d;
    if (out_load) begin
      out_pos_q  <= slot_q;
      out_bar_q  <= scl_height;
      out_fs_q   <= run_max_q;
      out_last_q <= !all_q || slot_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = POS_W'(out_pos_q);
  assign bar_height_o = out_bar_q;
  assign full_scale_o = out_fs_q;
  assign last_o       = out_last_q;

endmodule : autoscale_history_graph

`default_nettype wire

// File: sv/ahg_hist_mem.sv
// ----------------------------------------------------------------------------
// ahg_hist_mem
// History store: one-write, one-read synchronous RAM with per-entry valid
// bits. An entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ahg_hist_mem
  import ahg_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [SAMPLE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output      logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vld_q;
  logic [SAMPLE_W-1:0] rdata_q;
  logic                rvld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Valid bits stand in for clearing the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule : ahg_hist_mem

`default_nettype wire

// File: sv/ahg_scaler.sv
// ----------------------------------------------------------------------------
// ahg_scaler
// Bar height unit: round(v*bh/max) = floor((2*v*bh + max) / (2*max)),
// saturated at bh. Steps: multiply (SC_MUL), add/compare (SC_PRE), then a
// radix-4 restoring divider (SC_DIV).
// ----------------------------------------------------------------------------
`default_nettype none

module ahg_scaler
  import ahg_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire scale_req_t      req_i,
  output      logic            done_o,
  output      logic [BH_W-1:0] height_o
);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_PRE  = 2'd2;
  localparam logic [1:0] SC_DIV  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [1:0]          k_q, k_d;
  logic                done_q, done_d;
  scale_req_t          req_q;
  logic [PROD_W-1:0]   prod_q;
  logic [NUM_W-1:0]    rem_q, rem_d;
  logic [BH_W-1:0]     quo_q, quo_d;
  logic                sat_q, sat_d;
  logic [BH_W-1:0]     height_q, height_d;

  logic [DIV_W-1:0]    dv2;
  logic [NUM_W-1:0]    num;
  logic [NUM_W-1:0]    t_hi, t_lo, r_mid;
  logic [2:0]          b_hi, b_lo;

  assign dv2 = {req_q.divisor, 1'b0};
  assign num = {prod_q, 1'b0} + NUM_W'(req_q.divisor);

  // Two restoring steps per cycle
  assign b_hi  = {k_q, 1'b1};
  assign b_lo  = {k_q, 1'b0};
  assign t_hi  = NUM_W'(dv2) << b_hi;
  assign r_mid = (rem_q >= t_hi) ? (rem_q - t_hi) : rem_q;
  assign t_lo  = NUM_W'(dv2) << b_lo;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    sat_d    = sat_q;
    done_d   = 1'b0;
    height_d = height_q;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        state_d = SC_PRE;
      end
      SC_PRE: begin
        rem_d   = num;
        quo_d   = '0;
        sat_d   = num >= {dv2, 8'b0};
        k_d     = 2'd3;
        state_d = SC_DIV;
      end
      SC_DIV: begin
        quo_d[b_hi] = rem_q >= t_hi;
        quo_d[b_lo] = r_mid >= t_lo;
        rem_d       = (r_mid >= t_lo) ? (r_mid - t_lo) : r_mid;
        k_d         = k_q - 2'd1;
        if (k_q == 2'd0) begin
          done_d  = 1'b1;
          state_d = SC_IDLE;
          if (sat_q || (quo_d > req_q.full_height)) begin
            height_d = req_q.full_height;
          end else begin
            height_d = quo_d;
          end
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == SC_IDLE)) begin
      req_q <= req_i;
    end
    prod_q   <= req_q.value * req_q.full_height;
    k_q      <= k_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    sat_q    <= sat_d;
    height_q <= height_d;
  end

  assign done_o   = done_q;
  assign height_o = height_q;

endmodule : ahg_scaler

`default_nettype wire

// File: sv/ahg_checker.sv
// ----------------------------------------------------------------------------
// ahg_checker
// Port-level checks of the history graph, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ahg_checker
  import ahg_pkg::*;
#(
  parameter int unsigned SIZE = 64
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [POS_W-1:0] position_o,
  input wire logic             pready
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous transaction in work");

  // Reported slot lies inside the history
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(position_o) < SIZE))
    else $error("position outside history");

  // Configuration port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule : ahg_checker

bind autoscale_history_graph ahg_checker #(.SIZE(SIZE)) u_ahg_checker (.*);

`default_nettype wire

// File: verif/autoscale_history_graph_tb.sv
// ----------------------------------------------------------------------------
// autoscale_history_graph_tb
// Self-checking bench for the auto-scaling history graph. A scoreboard class
// keeps its own copy of the sample history, write slot, peak slot and running
// maximum, predicts every bar height a sample produces (single slot or full
// rescale), and checks each result transaction in order. Directed samples
// cover the field extremes and the corner cases; random phases then vary the
// registers and drive samples with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module autoscale_history_graph_tb
  import ahg_pkg::*;
();

  localparam int unsigned GRAPH_DEPTH = 64;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned MAX_REPORTS = 10;

  // One predicted result transaction
  typedef struct {
    logic [POS_W-1:0]    position;
    logic [BH_W-1:0]     bar_height;
    logic [SAMPLE_W-1:0] full_scale;
    logic                last;
  } bar_result_t;

  // Predicts the bar heights of the series and checks the result stream
  class bar_tracker;
    logic [SAMPLE_W-1:0] history [GRAPH_DEPTH];
    int unsigned         wr_slot;
    int unsigned         peak_slot;
    int unsigned         full_max;
    int unsigned         box_h;
    int unsigned         floor_val;
    bit                  autoscale;
    bar_result_t         expected_bars [$];
    int unsigned         errors;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_slot   = 0;
      peak_slot = 0;
      box_h     = FULL_HEIGHT_RST;
      floor_val = FLOOR_MAX_RST;
      full_max  = FLOOR_MAX_RST;
      autoscale = 1'b0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return expected_bars.size();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_FULL_HEIGHT: box_h = data[BH_W-1:0];
        REG_FLOOR_MAX: begin
          floor_val = data[SAMPLE_W-1:0];
          full_max  = floor_val;
        end
        REG_SCALE_EN: autoscale = data[0];
        default: ;
      endcase
    endfunction

    // round(v * box / max), saturated at box; a zero max divides by one
    function logic [BH_W-1:0] height_of(int unsigned v);
      longint unsigned div;
      longint unsigned h;
      div = (full_max != 0) ? full_max : 1;
      h = (2 * longint'(v) * box_h + div) / (2 * div);
      if (h > box_h) h = box_h;
      return h[BH_W-1:0];
    endfunction

    function void push_bar(int unsigned slot, bit fin);
      bar_result_t r;
      r.position   = slot[POS_W-1:0];
      r.bar_height = height_of(history[slot]);
      r.full_scale = full_max[SAMPLE_W-1:0];
      r.last       = fin;
      expected_bars.push_back(r);
    endfunction

    function void push_rescale();
      for (int unsigned u = 0; u < GRAPH_DEPTH; u++)
        push_bar(u, u == GRAPH_DEPTH - 1);
    endfunction

    // Accepted sample: store it, update the scale, queue the heights
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned v;
      int unsigned cand;
      v = s[SAMPLE_W-1] ? 0 : int'(s[SAMPLE_W-2:0]);
      wr_slot = (wr_slot + 1 >= GRAPH_DEPTH) ? 0 : wr_slot + 1;
      history[wr_slot] = v[SAMPLE_W-1:0];
      if (!autoscale) begin
        push_bar(wr_slot, 1'b1);
      end else if (v > full_max) begin
        // new peak
        peak_slot = wr_slot;
        full_max  = v;
        push_rescale();
      end else if (peak_slot == wr_slot && full_max > floor_val) begin
        // peak overwritten: rescan, ties keep the earlier candidate
        cand = wr_slot;
        for (int unsigned u = 0; u < GRAPH_DEPTH; u++)
          if (history[u] > history[cand]) cand = u;
        peak_slot = cand;
        full_max  = (history[cand] > floor_val) ? history[cand] : floor_val;
        push_rescale();
      end else begin
        push_bar(wr_slot, 1'b1);
      end
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic [BH_W-1:0] bh,
                               logic [SAMPLE_W-1:0] fs, logic fin);
      bar_result_t want;
      if (expected_bars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result: pos=%0d bar=%0d scale=%0d last=%0b",
                   $time, pos, bh, fs, fin);
        return;
      end
      want = expected_bars.pop_front();
      if (want.position !== pos || want.bar_height !== bh ||
          want.full_scale !== fs || want.last !== fin) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch: exp pos=%0d bar=%0d scale=%0d last=%0b",
                   $time, want.position, want.bar_height, want.full_scale,
                   want.last);
          $display("[%0t]           got pos=%0d bar=%0d scale=%0d last=%0b",
                   $time, pos, bh, fs, fin);
        end
      end
    endfunction
  endclass

  // Clock, reset and block signals
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [POS_W-1:0]           position_o;
  logic [BH_W-1:0]            bar_height_o;
  logic [SAMPLE_W-1:0]        full_scale_o;
  logic                       last_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [3:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  bar_tracker tracker = new();
  bit         no_idle = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  autoscale_history_graph #(
    .SIZE(GRAPH_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .bar_height_o(bar_height_o),
    .full_scale_o(full_scale_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random sample: mostly in [0, lim], some repeats of lim/2 for ties,
  // some negatives, and full-range noise when asked
  function automatic logic signed [SAMPLE_W-1:0] next_sample(int unsigned lim,
                                                            bit noisy);
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) return {1'b1, 15'($urandom)};
    if (r == 1 && noisy) return 16'($urandom);
    if (r < 4) return 16'(lim / 2);
    return 16'($urandom_range(0, lim));
  endfunction

  // Starts and ends at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_sample(s);
    @(negedge clk_i);
  endtask

  // Wait until every predicted result has come back
  task automatic drain();
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Result side: random back-pressure
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(position_o, bar_height_o, full_scale_o, last_o);
  end

  initial begin : stimulus
    int unsigned count [NUM_PHASES];
    int unsigned box, flr, lim;
    bit          scl;

    count = '{10, 66, 6, 6, 6, 6};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings, fixed scale: extremes, negatives, saturation
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd49);
    send_sample(16'sd99);
    send_sample(16'sd100);
    send_sample(16'sh7FFF);
    send_sample(-16'sd1);
    send_sample(16'sh8000);
    drain();

    // Auto-scale: single height, new peak, equal to peak, clamped negative
    reg_write(REG_SCALE_EN, 32'd1);
    send_sample(16'sd30);
    send_sample(16'sd150);
    send_sample(16'sd150);
    send_sample(-16'sd5);
    send_sample(16'sd200);
    drain();

    // Zero full scale and the widest box
    reg_write(REG_FULL_HEIGHT, 32'd255);
    reg_write(REG_FLOOR_MAX, 32'd0);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd7);
    drain();

    // Largest full scale, one-pixel box, both scale modes
    reg_write(REG_FULL_HEIGHT, 32'd1);
    reg_write(REG_FLOOR_MAX, 32'hFFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh4000);
    drain();
    reg_write(REG_SCALE_EN, 32'd0);
    send_sample(16'sh7FFF);
    drain();

    // Random phases; phase 1 holds one early peak long enough to be overwritten
    for (int unsigned k = 0; k < NUM_PHASES; k++) begin
      box = (k == 0) ? 255 : (k == 3) ? 1 : $urandom_range(1, 255);
      flr = (k == 2) ? 65535 : (k == 4) ? $urandom_range(1, 20) : $urandom_range(1, 2000);
      scl = (k == 1 || k == 4) ? 1'b1 : 1'($urandom_range(0, 1));
      no_idle = (k == 2);
      reg_write(REG_FULL_HEIGHT, box);
      reg_write(REG_FLOOR_MAX, flr);
      reg_write(REG_SCALE_EN, {31'd0, scl});
      if (k == 1) begin
        lim = flr * 3 + $urandom_range(1, 500);
        if (lim > 32767) lim = 32767;
        send_sample(16'(lim));
        for (int unsigned n = 1; n < count[k]; n++) send_sample(next_sample(lim, 1'b0));
      end else begin
        lim = (flr * 2 > 32767) ? 32767 : flr * 2;
        for (int unsigned n = 0; n < count[k]; n++) send_sample(next_sample(lim, 1'b1));
      end
      drain();
    end

    // Let any stray result show up
    repeat (40) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("autoscale_history_graph_tb: done, clean");
    else
      $display("autoscale_history_graph_tb: done, errors");
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("autoscale_history_graph_tb: done, errors");
    $finish;
  end

endmodule : autoscale_history_graph_tb

`default_nettype wire
